/* design/swhs_pkg.sv */
// Shared types and constants for the single-wire humidity sensor receiver.
`default_nettype none

package swhs_pkg;

  // Completed segments after which reception ends
  localparam logic [6:0] MAX_SEGMENTS = 7'd100;
  // First segment that carries a data bit
  localparam logic [6:0] FIRST_BIT_SEGMENT = 7'd3;
  // Mask of the first (most significant) bit of a data byte
  localparam logic [7:0] BYTE_MSB = 8'h80;
  // Number of data bytes in one reading
  localparam logic [2:0] NUM_BYTES = 3'd5;
  localparam logic [15:0] TICK_SATURATE = 16'hFFFF;

  // Configuration register indexes
  localparam logic [1:0] CFG_START_LOW    = 2'd0;
  localparam logic [1:0] CFG_RELEASE_WAIT = 2'd1;
  localparam logic [1:0] CFG_ONE_THRESH   = 2'd2;
  localparam logic [1:0] CFG_TIMEOUT      = 2'd3;

  // Configuration reset values
  localparam logic [15:0] START_LOW_RESET    = 16'd18000;
  localparam logic [9:0]  RELEASE_WAIT_RESET = 10'd40;
  localparam logic [7:0]  ONE_THRESH_RESET   = 8'd50;
  localparam logic [9:0]  TIMEOUT_RESET      = 10'd150;

  // Sequencer phases
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_DRIVE = 2'd1;
  localparam logic [1:0] PH_WAIT  = 2'd2;
  localparam logic [1:0] PH_RECV  = 2'd3;

  typedef struct packed {
    logic [15:0] start_low_ticks;
    logic [9:0]  release_wait_ticks;
    logic [7:0]  one_threshold_ticks;
    logic [9:0]  timeout_ticks;
  } swhs_cfg_t;

  typedef struct packed {
    logic operation;
    logic pin_level;
  } swhs_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] humidity_whole;
    logic [7:0] humidity_fraction;
    logic [7:0] temperature_whole;
    logic [7:0] temperature_fraction;
    logic [7:0] check_byte;
    logic       checksum_ok;
    logic       ended_by_timeout;
    logic [6:0] segments_seen;
  } swhs_out_t;

endpackage

`default_nettype wire

/* design/swhs_cfg.sv */
// Configuration register bank of the sensor receiver.
`default_nettype none

module swhs_cfg
  import swhs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i,
  output swhs_cfg_t        cfg_o
);

  swhs_cfg_t cfg_q;

  // Register writes, truncated to each register's width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_low_ticks     <= START_LOW_RESET;
      cfg_q.release_wait_ticks  <= RELEASE_WAIT_RESET;
      cfg_q.one_threshold_ticks <= ONE_THRESH_RESET;
      cfg_q.timeout_ticks       <= TIMEOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_LOW:    cfg_q.start_low_ticks     <= cfg_data_i;
        CFG_RELEASE_WAIT: cfg_q.release_wait_ticks  <= cfg_data_i[9:0];
        CFG_ONE_THRESH:   cfg_q.one_threshold_ticks <= cfg_data_i[7:0];
        CFG_TIMEOUT:      cfg_q.timeout_ticks       <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

/* design/swhs_engine.sv */
// Receive sequencer: phase, segment timer, bit packer and result formation.
`default_nettype none

module swhs_engine
  import swhs_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire swhs_in_t  item_i,
  input  wire swhs_cfg_t cfg_i,
  output swhs_out_t      res_o
);

  logic [1:0]  phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic        prev_q, prev_d;
  logic [6:0]  seg_q, seg_d;
  logic [2:0]  bit_q, bit_d;
  logic [2:0]  byte_q, byte_d;
  logic [7:0]  bytes_q [5];
  logic [7:0]  bytes_d [5];

  logic [15:0] tick_plus;
  logic [15:0] tick_sat;
  logic        done;
  logic        by_timeout;
  logic [7:0]  sum;

  // Next state for one transaction
  always_comb begin
    phase_d    = phase_q;
    tick_d     = tick_q;
    prev_d     = prev_q;
    seg_d      = seg_q;
    bit_d      = bit_q;
    byte_d     = byte_q;
    bytes_d    = bytes_q;
    done       = 1'b0;
    by_timeout = 1'b0;
    tick_plus  = tick_q + 16'd1;
    tick_sat   = (tick_q != TICK_SATURATE) ? tick_plus : tick_q;

    if (item_i.operation) begin
      // Start request: restart the whole read
      for (int i = 0; i < 5; i++) begin
        bytes_d[i] = '0;
      end
      phase_d = PH_DRIVE;
      tick_d  = '0;
      prev_d  = 1'b0;
      seg_d   = '0;
      bit_d   = '0;
      byte_d  = '0;
    end else begin
      case (phase_q)
        PH_DRIVE: begin
          tick_d = tick_plus;
          if (tick_plus >= cfg_i.start_low_ticks) begin
            phase_d = PH_WAIT;
            tick_d  = '0;
          end
        end
        PH_WAIT: begin
          tick_d = tick_plus;
          if (tick_plus > {6'd0, cfg_i.release_wait_ticks}) begin
            phase_d = PH_RECV;
            tick_d  = '0;
            prev_d  = item_i.pin_level;
          end
        end
        PH_RECV: begin
          tick_d = tick_sat;
          if (item_i.pin_level != prev_q) begin
            // Segment completed: odd segments from the fourth on carry a bit
            if (seg_q >= FIRST_BIT_SEGMENT && seg_q[0] && byte_q < NUM_BYTES) begin
              if (tick_sat > {8'd0, cfg_i.one_threshold_ticks}) begin
                bytes_d[byte_q] = bytes_q[byte_q] | (BYTE_MSB >> bit_q);
              end
              bit_d = bit_q + 3'd1;
              if (bit_q == 3'd7) begin
                byte_d = byte_q + 3'd1;
              end
            end
            seg_d  = seg_q + 7'd1;
            tick_d = '0;
            prev_d = item_i.pin_level;
            if (seg_d >= MAX_SEGMENTS) begin
              done = 1'b1;
            end
          end else if (tick_sat > {6'd0, cfg_i.timeout_ticks}) begin
            done       = 1'b1;
            by_timeout = 1'b1;
          end
          if (done) begin
            phase_d = PH_IDLE;
          end
        end
        default: ;
      endcase
    end

    sum = bytes_d[0] + bytes_d[1] + bytes_d[2] + bytes_d[3];
  end

  // Result of this transaction
  always_comb begin
    res_o.drive_low            = (phase_d == PH_DRIVE);
    res_o.busy_res             = (phase_d != PH_IDLE);
    res_o.done_res             = done;
    res_o.humidity_whole       = bytes_d[0];
    res_o.humidity_fraction    = bytes_d[1];
    res_o.temperature_whole    = bytes_d[2];
    res_o.temperature_fraction = bytes_d[3];
    res_o.check_byte           = bytes_d[4];
    res_o.checksum_ok          = done && (sum == bytes_d[4]);
    res_o.ended_by_timeout     = done && by_timeout;
    res_o.segments_seen        = seg_d;
  end

  // State registers advance once per transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
      prev_q  <= 1'b0;
      seg_q   <= '0;
      bit_q   <= '0;
      byte_q  <= '0;
      for (int i = 0; i < 5; i++) begin
        bytes_q[i] <= '0;
      end
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      prev_q  <= prev_d;
      seg_q   <= seg_d;
      bit_q   <= bit_d;
      byte_q  <= byte_d;
      bytes_q <= bytes_d;
    end
  end

endmodule

`default_nettype wire

/* design/single_wire_humidity_sensor_receiver_top.sv */
// Top level of the single-wire humidity sensor receiver.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) carries one transaction
// per microsecond tick or start request: operation 1 starts a read, operation
// 0 is a tick with the sampled pin level. Every input transaction yields
// exactly one output transaction (out_valid_o / out_stall_i / out_data_o)
// with the line drive, busy and done flags, the five received bytes, the
// checksum verdict, the end cause and the segment count.
// The path is an input register, then the sequencer logic feeding the output
// register. Throughput is one transaction per cycle unless out_stall_i holds
// a result; the state updates per step, so back-to-back ticks see each other.
// When the consumer asserts out_stall_i with a result held, the held result
// stays put, the input register keeps its transaction, and in_stall_o rises
// only once both registers are full.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
// (0 start low ticks, 1 release wait, 2 one threshold, 3 timeout).
// Reset loads the default configuration, empties both registers, returns the
// sequencer to idle and clears the data bytes.
`default_nettype none

module single_wire_humidity_sensor_receiver_top
  import swhs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire swhs_in_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output swhs_out_t        out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  swhs_cfg_t cfg;
  swhs_out_t res;

  logic      in_valid_q;
  swhs_in_t  in_data_q;
  logic      out_valid_q;
  swhs_out_t out_data_q;
  logic      out_ready;
  logic      step;

  swhs_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  swhs_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_data_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  // Flow control between the two register stages
  assign out_ready  = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Reception ending returns the sequencer to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done reported while still busy");

  // Driving the line low only happens inside a read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.drive_low |-> out_data_o.busy_res)
    else $error("line driven low while idle");

  // End verdicts only accompany the end of reception
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.checksum_ok || out_data_o.ended_by_timeout)
      |-> out_data_o.done_res)
    else $error("end verdict without done");

  // Input is stalled only when both register stages are occupied
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

endmodule

`default_nettype wire
